// ===== hdl/aigdec_pkg.sv =====
package aigdec_pkg;

  localparam int unsigned VAR_W      = 31;
  localparam int unsigned LIT_W      = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CNT_W      = 3;

  localparam logic [BYTE_W-1:0] CONT_BIT  = 8'h80;
  localparam logic [BYTE_W-1:0] PAYLOAD_M = 8'h7f;
  localparam logic [CNT_W-1:0]  MAX_BYTES = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_GATE_VAR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_VAR       = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_ORDER = 2'd1,
    STATUS_OVF   = 2'd2
  } status_t;

  typedef struct packed {
    logic [LIT_W-1:0] lhs_lit;
    logic [LIT_W-1:0] rhs0_lit;
    logic [LIT_W-1:0] rhs1_lit;
    status_t          status;
    logic             last_gate;
  } gate_t;

endpackage

// ===== hdl/aigdec_in_if.sv =====
interface aigdec_in_if;
  import aigdec_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ===== hdl/aigdec_out_if.sv =====
interface aigdec_out_if;
  import aigdec_pkg::*;

  logic             valid;
  logic             ready;
  logic [LIT_W-1:0] lhs_lit;
  logic [LIT_W-1:0] rhs0_lit;
  logic [LIT_W-1:0] rhs1_lit;
  logic [1:0]       status;
  logic             last_gate;

  modport source (output valid, output lhs_lit, output rhs0_lit, output rhs1_lit,
                  output status, output last_gate, input ready);
  modport sink (input valid, input lhs_lit, input rhs0_lit, input rhs1_lit,
                input status, input last_gate, output ready);
endinterface

// ===== hdl/aig_binary_and_gate_decoder_unit.sv =====
// binary and-gate section decoder
//
// in_ch carries one raw byte of the binary and section per word. bytes are
// joined into 7-bit little-endian varints (top bit set: more bytes follow);
// two varints are the deltas of one gate. out_ch gives one word per gate:
// lhs, both operand literals, a status (ok, operand order, varint overflow)
// and a last-gate mark. bytes after the last gate are dropped unanswered.
//
// cfg_we/cfg_index/cfg_data write first_gate_var (index 0) and last_var
// (index 1); any write restarts decoding from first_gate_var. write only
// while no word is in flight.
//
// throughput: one byte per cycle while in_ready is high. a byte is decoded in
// the cycle it is taken; a completed gate goes to the result register, or to
// the skid register while out_ch stalls, so input keeps flowing; in_ready
// drops only when both hold an undelivered gate.
//
// reset (synchronous, rst_n low): first_gate_var 1, last_var 0, so the
// decoder comes up finished and ignores bytes until configured.
module aig_binary_and_gate_decoder_unit
  import aigdec_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  aigdec_in_if.sink            in_ch,
  aigdec_out_if.source         out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAR_W-1:0]     cfg_data
);

  // config registers
  logic [VAR_W-1:0] first_gate_var_r, first_gate_var_nxt;
  logic [VAR_W-1:0] last_var_r, last_var_nxt;

  // decode state
  logic [LIT_W-1:0] accum_r, accum_nxt;
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic             second_delta_r, second_delta_nxt;
  logic [LIT_W-1:0] first_operand_r, first_operand_nxt;
  logic [VAR_W-1:0] gate_var_r, gate_var_nxt;
  logic             overflow_seen_r, overflow_seen_nxt;
  logic             finished_r, finished_nxt;

  // result register and skid register
  logic  out_v_r, out_v_nxt;
  gate_t out_r, out_nxt;
  logic  skid_v_r, skid_v_nxt;
  gate_t skid_r, skid_nxt;

  logic             in_acc;
  logic             out_pop;
  logic [6:0]       payload;
  logic [LIT_W-1:0] part;
  logic             part_ovf;
  logic [LIT_W-1:0] accum_or;
  logic             ovf_now;
  logic [LIT_W-1:0] lhs;
  logic             order_bad;
  logic             gate_done;
  gate_t            gate;

  assign in_ch.ready = !skid_v_r;
  assign in_acc      = in_ch.valid && !skid_v_r;
  assign out_pop     = out_v_r && out_ch.ready;

  assign payload = in_ch.data_byte[6:0];

  // place the 7-bit payload at its varint position
  always_comb begin
    part     = '0;
    part_ovf = 1'b0;
    case (byte_count_r)
      3'd0: part = {25'd0, payload};
      3'd1: part = {18'd0, payload, 7'd0};
      3'd2: part = {11'd0, payload, 14'd0};
      3'd3: part = {4'd0, payload, 21'd0};
      3'd4: begin
        part     = {payload[3:0], 28'd0};
        part_ovf = |payload[6:4];
      end
      default: part_ovf = 1'b1;  // sixth or later byte
    endcase
  end

  assign accum_or  = accum_r | part;
  assign ovf_now   = overflow_seen_r | part_ovf;
  assign lhs       = {gate_var_r, 1'b0};
  assign order_bad = (first_operand_r >= lhs) || (accum_or > first_operand_r);

  always_comb begin
    gate.lhs_lit   = lhs;
    gate.rhs0_lit  = first_operand_r;
    gate.rhs1_lit  = first_operand_r - accum_or;
    gate.status    = ovf_now ? STATUS_OVF : (order_bad ? STATUS_ORDER : STATUS_OK);
    gate.last_gate = (gate_var_r == last_var_r);
  end

  // decoder next state
  always_comb begin
    first_gate_var_nxt = first_gate_var_r;
    last_var_nxt       = last_var_r;
    accum_nxt          = accum_r;
    byte_count_nxt     = byte_count_r;
    second_delta_nxt   = second_delta_r;
    first_operand_nxt  = first_operand_r;
    gate_var_nxt       = gate_var_r;
    overflow_seen_nxt  = overflow_seen_r;
    finished_nxt       = finished_r;
    gate_done          = 1'b0;

    if (cfg_we) begin
      if (cfg_index == REG_FIRST_GATE_VAR) begin
        first_gate_var_nxt = cfg_data;
      end else begin
        last_var_nxt = cfg_data;
      end
      accum_nxt         = '0;
      byte_count_nxt    = '0;
      second_delta_nxt  = 1'b0;
      first_operand_nxt = '0;
      overflow_seen_nxt = 1'b0;
      gate_var_nxt      = first_gate_var_nxt;
      finished_nxt      = first_gate_var_nxt > last_var_nxt;
    end else if (in_acc && !finished_r) begin
      overflow_seen_nxt = ovf_now;
      if ((in_ch.data_byte & CONT_BIT) != '0) begin
        accum_nxt = accum_or;
        if (byte_count_r < MAX_BYTES) begin
          byte_count_nxt = byte_count_r + 3'd1;
        end
      end else begin
        accum_nxt      = '0;
        byte_count_nxt = '0;
        if (!second_delta_r) begin
          first_operand_nxt = lhs - accum_or;
          second_delta_nxt  = 1'b1;
        end else begin
          gate_done         = 1'b1;
          finished_nxt      = gate.last_gate;
          gate_var_nxt      = gate_var_r + 31'd1;
          second_delta_nxt  = 1'b0;
          first_operand_nxt = '0;
          overflow_seen_nxt = 1'b0;
        end
      end
    end
  end

  // result register with skid
  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (out_pop) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (gate_done) begin
      if (!out_v_r || out_pop) begin
        out_v_nxt = 1'b1;
        out_nxt   = gate;
      end else begin
        skid_v_nxt = 1'b1;
        skid_nxt   = gate;
      end
    end else if (out_pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_gate_var_r <= 31'd1;
      last_var_r       <= '0;
      accum_r          <= '0;
      byte_count_r     <= '0;
      second_delta_r   <= 1'b0;
      first_operand_r  <= '0;
      gate_var_r       <= 31'd1;
      overflow_seen_r  <= 1'b0;
      finished_r       <= 1'b1;
      out_v_r          <= 1'b0;
      skid_v_r         <= 1'b0;
    end else begin
      first_gate_var_r <= first_gate_var_nxt;
      last_var_r       <= last_var_nxt;
      accum_r          <= accum_nxt;
      byte_count_r     <= byte_count_nxt;
      second_delta_r   <= second_delta_nxt;
      first_operand_r  <= first_operand_nxt;
      gate_var_r       <= gate_var_nxt;
      overflow_seen_r  <= overflow_seen_nxt;
      finished_r       <= finished_nxt;
      out_v_r          <= out_v_nxt;
      skid_v_r         <= skid_v_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.lhs_lit   = out_r.lhs_lit;
  assign out_ch.rhs0_lit  = out_r.rhs0_lit;
  assign out_ch.rhs1_lit  = out_r.rhs1_lit;
  assign out_ch.status    = out_r.status;
  assign out_ch.last_gate = out_r.last_gate;

  // skid only fills behind a held result
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a gate while result register is empty");

  // only a config write leaves the finished state
  a_finished_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    (finished_r && !cfg_we) |=> finished_r)
    else $error("finished cleared without a config write");

  // no new gate is produced once finished
  a_no_gate_finished : assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> !gate_done)
    else $error("gate produced after last gate");

  // an ok gate has rhs0 below lhs and rhs1 not above rhs0
  a_ok_order : assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.status == STATUS_OK) |->
      (out_r.rhs0_lit < out_r.lhs_lit && out_r.rhs1_lit <= out_r.rhs0_lit))
    else $error("status ok on a misordered gate");

endmodule
